FILE: sv/sfd_pkg.sv
package sfd_pkg;

    // frame layout
    localparam int STORE_DEPTH = 25;
    localparam int NUM_CH      = 9;
    localparam int CH_BITS     = 11;
    localparam int STREAM_BITS = NUM_CH * CH_BITS;
    localparam int HEAD_POS    = 0;
    localparam int END_POS     = 24;
    localparam int FLAG_POS    = 23;

    // configuration register indexes
    localparam logic [2:0] CFG_HEAD    = 3'd0;
    localparam logic [2:0] CFG_END     = 3'd1;
    localparam logic [2:0] CFG_OFFLINE = 3'd2;
    localparam logic [2:0] CFG_BOTTOM  = 3'd3;
    localparam logic [2:0] CFG_TOP     = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_ONLINE  = 3'd0;
    localparam logic [2:0] KIND_RAW     = 3'd1;
    localparam logic [2:0] KIND_PERCENT = 3'd2;
    localparam logic [2:0] KIND_ANGLE   = 3'd3;
    localparam logic [2:0] KIND_MAG     = 3'd4;

    // result slots within a frame
    localparam logic [4:0] SLOT_FIRST_PCT = 5'd10;
    localparam logic [4:0] SLOT_FIRST_ANG = 5'd14;
    localparam logic [4:0] SLOT_FIRST_MAG = 5'd16;
    localparam logic [4:0] SLOT_LAST      = 5'd17;

    // arithmetic constants
    localparam logic signed [35:0] PI_Q30     = 36'sd3373259426;
    localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51471;
    localparam logic signed [28:0] PCT_FULL   = 29'sd25600;
    localparam logic [15:0]        PCT_SCALE  = 16'd51200;
    localparam logic [15:0]        MAG_MAX    = 16'd100;
    localparam int                 DIV_STEPS  = 27;
    localparam int                 SQRT_STEPS = 16;

    // one checked frame handed from front to back
    typedef struct packed {
        logic                   online;
        logic [STREAM_BITS-1:0] stream;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SEL,
        BK_DIV,
        BK_DIV_FIN,
        BK_COR,
        BK_COR_FIN,
        BK_SQ1,
        BK_SQ2,
        BK_SQRT,
        BK_MAG_FIN,
        BK_PUT
    } bk_state_t;

    // arctangent of 2^-i in Q2.30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/sfd_front.sv
module sfd_front #(
    parameter int FRAME_LENGTH = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    input  logic              frame_start,
    input  logic [7:0]        head_byte,
    input  logic [7:0]        end_byte,
    input  logic [7:0]        offline_value,
    input  logic              q_full,
    output logic              push,
    output sfd_pkg::job_t     push_job
);

    logic [7:0] store_reg [sfd_pkg::STORE_DEPTH];
    logic [4:0] count_reg;
    logic [4:0] pos;
    logic       take;
    logic       active;
    logic       last_byte;
    logic [7:0] eff [sfd_pkg::STORE_DEPTH];
    logic       good;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;
    assign active   = frame_start || (count_reg != 5'd0);
    assign pos      = frame_start ? 5'd0 : count_reg;
    assign last_byte = (pos == 5'(FRAME_LENGTH - 1));

    // frame bytes with the byte now arriving folded in
    always_comb
    begin
        for (int j = 0; j < sfd_pkg::STORE_DEPTH; j++)
        begin
            eff[j] = (pos == 5'(j)) ? rx_byte : store_reg[j];
        end
    end

    assign good = (eff[sfd_pkg::HEAD_POS] == head_byte) && (eff[sfd_pkg::END_POS] == end_byte);

    // job: online flag and the channel bit stream from byte 1 on
    always_comb
    begin
        push_job.online = (eff[sfd_pkg::FLAG_POS] != offline_value);
        for (int j = 0; j < sfd_pkg::STREAM_BITS; j++)
        begin
            push_job.stream[j] = eff[1 + j / 8][j % 8];
        end
    end

    assign push = take && active && last_byte && good;

    // byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd0;
        end
        else if (take && active)
        begin
            count_reg <= last_byte ? 5'd0 : pos + 5'd1;
        end
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (take && active && (pos < 5'(sfd_pkg::STORE_DEPTH)))
        begin
            store_reg[pos] <= rx_byte;
        end
    end

endmodule

FILE: sv/sfd_queue.sv
module sfd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sfd_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sfd_pkg::job_t head_job
);

    sfd_pkg::job_t mem_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    fill_reg;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_job   = mem_reg[rptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

endmodule

FILE: sv/sfd_back.sv
module sfd_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  sfd_pkg::job_t      job,
    output logic               pop,
    input  logic [10:0]        channel_bottom,
    input  logic [10:0]        channel_top,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         result_kind,
    output logic [3:0]         item_index,
    output logic signed [16:0] item_value,
    output logic               last_of_frame
);

    sfd_pkg::bk_state_t state_reg, state_next;

    logic [4:0]         slot_reg;
    logic [4:0]         cnt_reg;
    logic signed [16:0] val_reg;
    logic signed [16:0] pc_reg [4];
    logic [26:0]        num_reg;
    logic [10:0]        rem_reg;
    logic               neg_reg;
    logic signed [24:0] xs_reg;
    logic signed [24:0] ys_reg;
    logic signed [35:0] z_reg;
    logic [31:0]        s_reg;
    logic [31:0]        r_reg;
    logic [31:0]        bit_reg;
    logic               ovalid_reg;

    logic [3:0]         ch_sel;
    logic [10:0]        ch_val;
    logic [10:0]        divisor;
    logic               top_ok;
    logic signed [11:0] diff;
    logic [10:0]        diff_mag;
    logic [11:0]        rem_sh;
    logic               rem_ge;
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [24:0] tx;
    logic signed [24:0] ty;
    logic signed [28:0] qs;
    logic signed [28:0] qt;
    logic signed [35:0] zr;
    logic signed [18:0] ang;
    logic [31:0]        rb;
    logic signed [33:0] sq;
    logic               out_free;
    logic               cor_done;
    logic [2:0]         kind;
    logic [3:0]         idx;

    // channel picked by the current slot
    always_comb
    begin
        if (slot_reg >= sfd_pkg::SLOT_FIRST_PCT)
        begin
            ch_sel = 4'(slot_reg - sfd_pkg::SLOT_FIRST_PCT);
        end
        else
        begin
            ch_sel = 4'(slot_reg - 5'd1);
        end
        ch_val = 11'd0;
        for (int k = 0; k < sfd_pkg::NUM_CH; k++)
        begin
            if (ch_sel == 4'(k))
            begin
                ch_val = job.stream[k * sfd_pkg::CH_BITS +: sfd_pkg::CH_BITS];
            end
        end
    end

    // percent setup and divider step
    assign top_ok   = channel_top > channel_bottom;
    assign divisor  = channel_top - channel_bottom;
    assign diff     = $signed({1'b0, ch_val}) - $signed({1'b0, channel_bottom});
    assign diff_mag = diff[11] ? 11'(-diff) : diff[10:0];
    assign rem_sh   = {rem_reg, num_reg[26]};
    assign rem_ge   = rem_sh >= {1'b0, divisor};
    assign qs       = neg_reg ? -$signed({2'b00, num_reg}) : $signed({2'b00, num_reg});
    assign qt       = qs - sfd_pkg::PCT_FULL;

    // stick vectors: left is channels 3/2, right is channels 0/1
    assign ax = slot_reg[0] ? pc_reg[0] : pc_reg[3];
    assign ay = slot_reg[0] ? pc_reg[1] : pc_reg[2];

    assign tx       = xs_reg >>> cnt_reg;
    assign ty       = ys_reg >>> cnt_reg;
    assign cor_done = (cnt_reg == 5'(CORDIC_STEPS)) || (ys_reg == 25'sd0);
    assign zr       = (z_reg + 36'sd65536) >>> 17;
    assign ang      = zr[18] ? zr[18:0] + sfd_pkg::TWO_PI_Q13 : zr[18:0];

    assign rb = r_reg + bit_reg;
    assign sq = (state_reg == sfd_pkg::BK_SQ1) ? ax * ax : ay * ay;

    assign out_free = !ovalid_reg || !out_stall;

    // kind and index of the current slot
    always_comb
    begin
        if (slot_reg == 5'd0)
        begin
            kind = sfd_pkg::KIND_ONLINE;
            idx  = 4'd0;
        end
        else if (slot_reg < sfd_pkg::SLOT_FIRST_PCT)
        begin
            kind = sfd_pkg::KIND_RAW;
            idx  = 4'(slot_reg - 5'd1);
        end
        else if (slot_reg < sfd_pkg::SLOT_FIRST_ANG)
        begin
            kind = sfd_pkg::KIND_PERCENT;
            idx  = 4'(slot_reg - sfd_pkg::SLOT_FIRST_PCT);
        end
        else if (slot_reg < sfd_pkg::SLOT_FIRST_MAG)
        begin
            kind = sfd_pkg::KIND_ANGLE;
            idx  = 4'(slot_reg - sfd_pkg::SLOT_FIRST_ANG);
        end
        else
        begin
            kind = sfd_pkg::KIND_MAG;
            idx  = 4'(slot_reg - sfd_pkg::SLOT_FIRST_MAG);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfd_pkg::BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = sfd_pkg::BK_SEL;
                end
            end
            sfd_pkg::BK_SEL:
            begin
                if (slot_reg < sfd_pkg::SLOT_FIRST_PCT)
                begin
                    state_next = sfd_pkg::BK_PUT;
                end
                else if (slot_reg < sfd_pkg::SLOT_FIRST_ANG)
                begin
                    state_next = top_ok ? sfd_pkg::BK_DIV : sfd_pkg::BK_PUT;
                end
                else if (slot_reg < sfd_pkg::SLOT_FIRST_MAG)
                begin
                    state_next = sfd_pkg::BK_COR;
                end
                else
                begin
                    state_next = sfd_pkg::BK_SQ1;
                end
            end
            sfd_pkg::BK_DIV:
            begin
                if (cnt_reg == 5'(sfd_pkg::DIV_STEPS - 1))
                begin
                    state_next = sfd_pkg::BK_DIV_FIN;
                end
            end
            sfd_pkg::BK_DIV_FIN: state_next = sfd_pkg::BK_PUT;
            sfd_pkg::BK_COR:
            begin
                if (cor_done)
                begin
                    state_next = sfd_pkg::BK_COR_FIN;
                end
            end
            sfd_pkg::BK_COR_FIN: state_next = sfd_pkg::BK_PUT;
            sfd_pkg::BK_SQ1:     state_next = sfd_pkg::BK_SQ2;
            sfd_pkg::BK_SQ2:     state_next = sfd_pkg::BK_SQRT;
            sfd_pkg::BK_SQRT:
            begin
                if (cnt_reg == 5'(sfd_pkg::SQRT_STEPS - 1))
                begin
                    state_next = sfd_pkg::BK_MAG_FIN;
                end
            end
            sfd_pkg::BK_MAG_FIN: state_next = sfd_pkg::BK_PUT;
            sfd_pkg::BK_PUT:
            begin
                if (out_free)
                begin
                    state_next = (slot_reg == sfd_pkg::SLOT_LAST) ? sfd_pkg::BK_IDLE
                                                                  : sfd_pkg::BK_SEL;
                end
            end
            default: state_next = sfd_pkg::BK_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        pop = (state_reg == sfd_pkg::BK_PUT) && out_free && (slot_reg == sfd_pkg::SLOT_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sfd_pkg::BK_IDLE;
            slot_reg   <= 5'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sfd_pkg::BK_IDLE)
            begin
                slot_reg <= 5'd0;
            end
            else if ((state_reg == sfd_pkg::BK_PUT) && out_free)
            begin
                slot_reg <= slot_reg + 5'd1;
            end
            if (out_free)
            begin
                ovalid_reg <= (state_reg == sfd_pkg::BK_PUT);
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if ((state_reg == sfd_pkg::BK_PUT) && out_free)
        begin
            result_kind   <= kind;
            item_index    <= idx;
            item_value    <= val_reg;
            last_of_frame <= (slot_reg == sfd_pkg::SLOT_LAST);
        end
    end

    assign out_valid = ovalid_reg;

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sfd_pkg::BK_SEL:
            begin
                cnt_reg <= 5'd0;
                if (slot_reg == 5'd0)
                begin
                    val_reg <= {16'd0, job.online};
                end
                else if (slot_reg < sfd_pkg::SLOT_FIRST_PCT)
                begin
                    val_reg <= {6'd0, ch_val};
                end
                else if (slot_reg < sfd_pkg::SLOT_FIRST_ANG)
                begin
                    num_reg <= 27'(diff_mag * sfd_pkg::PCT_SCALE);
                    neg_reg <= diff[11];
                    rem_reg <= 11'd0;
                    if (!top_ok)
                    begin
                        val_reg <= 17'sd0;
                        pc_reg[2'(slot_reg - sfd_pkg::SLOT_FIRST_PCT)] <= 17'sd0;
                    end
                end
                else if (slot_reg < sfd_pkg::SLOT_FIRST_MAG)
                begin
                    if (ax < 0)
                    begin
                        z_reg  <= (ay >= 0) ? sfd_pkg::PI_Q30 : -sfd_pkg::PI_Q30;
                        xs_reg <= 25'(-ax) <<< 6;
                        ys_reg <= 25'(-ay) <<< 6;
                    end
                    else
                    begin
                        z_reg  <= 36'sd0;
                        xs_reg <= 25'(ax) <<< 6;
                        ys_reg <= 25'(ay) <<< 6;
                    end
                end
            end
            sfd_pkg::BK_DIV:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (rem_ge)
                begin
                    rem_reg <= 11'(rem_sh - {1'b0, divisor});
                end
                else
                begin
                    rem_reg <= rem_sh[10:0];
                end
                num_reg <= {num_reg[25:0], rem_ge};
            end
            sfd_pkg::BK_DIV_FIN:
            begin
                if (qt > sfd_pkg::PCT_FULL)
                begin
                    val_reg <= 17'(sfd_pkg::PCT_FULL);
                    pc_reg[2'(slot_reg - sfd_pkg::SLOT_FIRST_PCT)] <= 17'(sfd_pkg::PCT_FULL);
                end
                else if (qt < -sfd_pkg::PCT_FULL)
                begin
                    val_reg <= 17'(-sfd_pkg::PCT_FULL);
                    pc_reg[2'(slot_reg - sfd_pkg::SLOT_FIRST_PCT)] <= 17'(-sfd_pkg::PCT_FULL);
                end
                else
                begin
                    val_reg <= qt[16:0];
                    pc_reg[2'(slot_reg - sfd_pkg::SLOT_FIRST_PCT)] <= qt[16:0];
                end
            end
            sfd_pkg::BK_COR:
            begin
                if (!cor_done)
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (ys_reg > 0)
                    begin
                        xs_reg <= xs_reg + ty;
                        ys_reg <= ys_reg - tx;
                        z_reg  <= z_reg + $signed({4'd0, sfd_pkg::atan_q30(cnt_reg)});
                    end
                    else
                    begin
                        xs_reg <= xs_reg - ty;
                        ys_reg <= ys_reg + tx;
                        z_reg  <= z_reg - $signed({4'd0, sfd_pkg::atan_q30(cnt_reg)});
                    end
                end
            end
            sfd_pkg::BK_COR_FIN:
            begin
                val_reg <= ang[16:0];
            end
            sfd_pkg::BK_SQ1:
            begin
                s_reg <= sq[31:0];
            end
            sfd_pkg::BK_SQ2:
            begin
                s_reg   <= s_reg + sq[31:0];
                r_reg   <= 32'd0;
                bit_reg <= 32'h4000_0000;
                cnt_reg <= 5'd0;
            end
            sfd_pkg::BK_SQRT:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (s_reg >= rb)
                begin
                    s_reg <= s_reg - rb;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            sfd_pkg::BK_MAG_FIN:
            begin
                if (r_reg[31:8] > {8'd0, sfd_pkg::MAG_MAX})
                begin
                    val_reg <= 17'(sfd_pkg::MAG_MAX);
                end
                else
                begin
                    val_reg <= 17'(r_reg[31:8]);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: sv/sbus_frame_decoder_with_sticks.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    rx_byte, frame_start
// out      out_valid / out_stall  result_kind, item_index, item_value, last_of_frame
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle; the front stalls only while its two-frame queue is full.
// A good frame yields 18 results, computed by the serial divider for percents (skipped when
// top is not above bottom), the CORDIC unit (one step per cycle) for angles and the
// bit-serial square root for magnitudes.
// rst_n clears the counters, queue and sequencer; config returns to its defaults.
// A stalled output holds its result; the back waits without losing work.
module sbus_frame_decoder_with_sticks #(
    parameter int FRAME_LENGTH = 25,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         result_kind,
    output logic [3:0]         item_index,
    output logic signed [16:0] item_value,
    output logic               last_of_frame,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [10:0]        cfg_data
);

    logic [7:0]    head_reg;
    logic [7:0]    end_reg;
    logic [7:0]    offline_reg;
    logic [10:0]   bottom_reg;
    logic [10:0]   top_reg;
    logic          push;
    logic          q_full;
    logic          pop;
    logic          head_valid;
    sfd_pkg::job_t push_job;
    sfd_pkg::job_t head_job;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= 8'd15;
            end_reg     <= 8'd0;
            offline_reg <= 8'd12;
            bottom_reg  <= 11'd172;
            top_reg     <= 11'd1811;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sfd_pkg::CFG_HEAD:    head_reg    <= cfg_data[7:0];
                sfd_pkg::CFG_END:     end_reg     <= cfg_data[7:0];
                sfd_pkg::CFG_OFFLINE: offline_reg <= cfg_data[7:0];
                sfd_pkg::CFG_BOTTOM:  bottom_reg  <= cfg_data;
                sfd_pkg::CFG_TOP:     top_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    sfd_front #(
        .FRAME_LENGTH(FRAME_LENGTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .frame_start   (frame_start),
        .head_byte     (head_reg),
        .end_byte      (end_reg),
        .offline_value (offline_reg),
        .q_full        (q_full),
        .push          (push),
        .push_job      (push_job)
    );

    sfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    sfd_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (head_valid),
        .job            (head_job),
        .pop            (pop),
        .channel_bottom (bottom_reg),
        .channel_top    (top_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .item_index     (item_index),
        .item_value     (item_value),
        .last_of_frame  (last_of_frame)
    );

endmodule
